// ----- rtl/crt_pkg.sv -----
// Shared constants, types and states for the character code remap table.
package crt_pkg;

    localparam int CODE_W           = 16;
    localparam int LOW_SIZE         = 256;
    localparam int LOW_AW           = $clog2(LOW_SIZE);
    localparam int HIGH_ENTRIES_DEF = 256;
    localparam int MODE_W           = 2;

    // Unmapped-code handling; every other mode value discards
    localparam logic [MODE_W-1:0] MODE_LEAVE = 2'd1;

    // Command codes
    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // One entry of the sorted high-code list
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CODE_W-1:0] newc;
    } crt_entry_t;

    localparam int ENTRY_W = 2 * CODE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOW,
        S_LOW_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } crt_state_t;

endpackage

// ----- rtl/crt_if.sv -----
// Request and response channel interfaces of the code remap table.
interface crt_req_if
    import crt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] replacement;
    logic              map_to_self;

    modport source (output valid, cmd, code, replacement, map_to_self, input ready);
    modport sink   (input valid, cmd, code, replacement, map_to_self, output ready);
endinterface

interface crt_rsp_if
    import crt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              ok;
    logic              found;
    logic [CODE_W-1:0] result_code;

    modport source (output valid, ok, found, result_code, input ready);
    modport sink   (input valid, ok, found, result_code, output ready);
endinterface

// ----- rtl/crt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/char_code_remap_table.sv -----
// Top level: two-level character code remap table with sequenced list search.
//
//  channel | dir | handshake          | word
//  --------+-----+--------------------+-------------------------------------------
//  req     | in  | valid/ready        | cmd, code, replacement, map_to_self
//  rsp     | out | valid/ready        | ok, found, result_code
//  cfg     | in  | cfg_we (no ready)  | cfg_wdata = default_mode
//
// Every word is taken in the idle state. After that, a low code (below 256)
// set does a table write, then a response load. A low lookup does a table read, a
// valid check, then a response load.
// High codes walk the sorted list downward through one RAM read port, a read and a check
// per entry above the code before it stops; an insert then moves each of those entries
// up, a read and a write each, then writes the new entry, then loads the response.
// Reset clears the low-table valid bits, the list count and the mode; no clearing pass.
// req is not ready while a word is in work; a finished response waits in the output
// register, and the next word is taken meanwhile.
module char_code_remap_table
    import crt_pkg::*;
#(
    parameter int HIGH_ENTRIES = HIGH_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [MODE_W-1:0] cfg_wdata,
    crt_req_if.sink           req,
    crt_rsp_if.source         rsp
);

    localparam int IDX_W = (HIGH_ENTRIES > 1) ? $clog2(HIGH_ENTRIES) : 1;
    localparam int CNT_W = $clog2(HIGH_ENTRIES + 1);

    crt_state_t          state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [LOW_SIZE-1:0] low_valid_reg, low_valid_next;

    logic                cmd_reg, cmd_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [CODE_W-1:0]   newc_reg, newc_next;

    logic                pend_ok_reg, pend_ok_next;
    logic                pend_found_reg, pend_found_next;
    logic [CODE_W-1:0]   pend_code_reg, pend_code_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    logic                out_found_reg, out_found_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;

    // RAM ports
    logic                low_we;
    logic [CODE_W-1:0]   low_rdata;
    logic                hi_we;
    logic [IDX_W-1:0]    hi_waddr;
    crt_entry_t          hi_wdata;
    logic [IDX_W-1:0]    hi_raddr;
    logic [ENTRY_W-1:0]  hi_rdata;
    crt_entry_t          hi_entry;

    logic                accept;
    logic                at_miss;
    logic [CNT_W-1:0]    i_dec;
    logic [CNT_W-1:0]    j_dec;

    assign accept   = req.valid && req.ready;
    assign i_dec    = i_reg - CNT_W'(1);
    assign j_dec    = j_reg - CNT_W'(1);
    assign hi_entry = crt_entry_t'(hi_rdata);

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_ok_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.result_code = out_code_reg;

    // Direct table for low codes; valid bits live in flops
    crt_ram #(
        .WIDTH (CODE_W),
        .DEPTH (LOW_SIZE)
    ) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (code_reg[LOW_AW-1:0]),
        .wdata (newc_reg),
        .raddr (code_reg[LOW_AW-1:0]),
        .rdata (low_rdata)
    );

    // Sorted list for high codes
    crt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HIGH_ENTRIES)
    ) u_high_ram (
        .clk   (clk),
        .we    (hi_we),
        .waddr (hi_waddr),
        .wdata (hi_wdata),
        .raddr (hi_raddr),
        .rdata (hi_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= '0;
            count_reg     <= '0;
            low_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            low_valid_reg <= low_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scan registers
    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        cmd_reg        <= cmd_next;
        code_reg       <= code_next;
        newc_reg       <= newc_next;
        pend_ok_reg    <= pend_ok_next;
        pend_found_reg <= pend_found_next;
        pend_code_reg  <= pend_code_next;
        out_ok_reg     <= out_ok_next;
        out_found_reg  <= out_found_next;
        out_code_reg   <= out_code_next;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = cfg_we ? cfg_wdata : mode_reg;
        count_next      = count_reg;
        low_valid_next  = low_valid_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        cmd_next        = cmd_reg;
        code_next       = code_reg;
        newc_next       = newc_reg;
        pend_ok_next    = pend_ok_reg;
        pend_found_next = pend_found_reg;
        pend_code_next  = pend_code_reg;
        out_valid_next  = out_valid_reg;
        out_ok_next     = out_ok_reg;
        out_found_next  = out_found_reg;
        out_code_next   = out_code_reg;
        low_we          = 1'b0;
        hi_we           = 1'b0;
        hi_waddr        = i_dec[IDX_W-1:0];
        hi_wdata        = '{code: code_reg, newc: newc_reg};
        hi_raddr        = i_dec[IDX_W-1:0];
        at_miss         = 1'b0;

        // response register drains independently
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = req.cmd;
                    code_next = req.code;
                    newc_next = req.map_to_self ? req.code : req.replacement;
                    i_next    = count_reg;
                    j_next    = count_reg;
                    if (req.code[CODE_W-1:LOW_AW] == '0)
                    begin
                        state_next = S_LOW;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_LOW:
            begin
                if (cmd_reg == CMD_SET)
                begin
                    low_we = 1'b1;
                    low_valid_next[code_reg[LOW_AW-1:0]] = 1'b1;
                    pend_ok_next    = 1'b1;
                    pend_found_next = 1'b0;
                    pend_code_next  = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    state_next = S_LOW_CHK;
                end
            end

            S_LOW_CHK:
            begin
                if (low_valid_reg[code_reg[LOW_AW-1:0]])
                begin
                    pend_ok_next    = 1'b1;
                    pend_found_next = 1'b1;
                    pend_code_next  = low_rdata;
                    state_next      = S_RESP;
                end
                else
                begin
                    at_miss = 1'b1;
                end
            end

            S_SRCH_RD:
            begin
                if (i_reg == '0)
                begin
                    at_miss = 1'b1;
                end
                else
                begin
                    state_next = S_SRCH_CHK;
                end
            end

            S_SRCH_CHK:
            begin
                if (hi_entry.code > code_reg)
                begin
                    i_next     = i_dec;
                    state_next = S_SRCH_RD;
                end
                else if (hi_entry.code == code_reg)
                begin
                    pend_ok_next = 1'b1;
                    state_next   = S_RESP;
                    if (cmd_reg == CMD_SET)
                    begin
                        // update in place at the matching slot
                        hi_we           = 1'b1;
                        pend_found_next = 1'b0;
                        pend_code_next  = '0;
                    end
                    else
                    begin
                        pend_found_next = 1'b1;
                        pend_code_next  = hi_entry.newc;
                    end
                end
                else
                begin
                    at_miss = 1'b1;
                end
            end

            S_SHIFT_RD:
            begin
                if (j_reg == i_reg)
                begin
                    // gap is open: drop the new entry in
                    hi_we           = 1'b1;
                    hi_waddr        = i_reg[IDX_W-1:0];
                    count_next      = count_reg + CNT_W'(1);
                    pend_ok_next    = 1'b1;
                    pend_found_next = 1'b0;
                    pend_code_next  = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    hi_raddr   = j_dec[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                // move one entry up by a slot
                hi_we      = 1'b1;
                hi_waddr   = j_reg[IDX_W-1:0];
                hi_wdata   = hi_entry;
                j_next     = j_dec;
                state_next = S_SHIFT_RD;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = pend_ok_reg;
                    out_found_next = pend_found_reg;
                    out_code_next  = pend_code_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // code not in either table
        if (at_miss)
        begin
            if (cmd_reg == CMD_LOOKUP)
            begin
                pend_ok_next    = 1'b1;
                pend_found_next = (mode_reg == MODE_LEAVE);
                pend_code_next  = (mode_reg == MODE_LEAVE) ? code_reg : '0;
                state_next      = S_RESP;
            end
            else if (count_reg == CNT_W'(HIGH_ENTRIES))
            begin
                pend_ok_next    = 1'b0;
                pend_found_next = 1'b0;
                pend_code_next  = '0;
                state_next      = S_RESP;
            end
            else
            begin
                state_next = S_SHIFT_RD;
            end
        end
    end

`ifndef SYNTH
    // list never holds more entries than its depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(HIGH_ENTRIES))
        else $error("high list count overflow");

    // list only grows, one entry at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("high list count jumped");

    // a failed set never reports a found code
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ok |-> !rsp.found && rsp.result_code == '0)
        else $error("failed set carries lookup data");

    // a word in work blocks the request channel
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> !req.ready)
        else $error("request taken while busy");
`endif

endmodule
